### src/eyq_pkg.sv
// Package with the shared constants, types and arctangent table of the Euler to quaternion core.
package eyq_pkg;

	localparam int AngleWidth  = 16;
	localparam int QuatWidth   = 16;
	localparam int CordicIters = 20;
	localparam int CordicWidth = 24;

	localparam logic signed [CordicWidth-1:0] CordicGainQ20 = 24'sd636751;
	localparam logic signed [CordicWidth-1:0] PiQ20         = 24'sd3294199;
	localparam logic signed [CordicWidth-1:0] HalfPiQ20     = 24'sd1647099;
	localparam logic signed [QuatWidth-1:0]   QuatMax       = 16'sd16384;

	typedef logic signed [CordicWidth-1:0] cval_t;

	// Payload of an input request: three Q3.12 angles.
	typedef struct packed {
		logic signed [AngleWidth-1:0] angle_x;
		logic signed [AngleWidth-1:0] angle_y;
		logic signed [AngleWidth-1:0] angle_z;
	} angles_t;

	// Payload of a result: the four Q1.14 quaternion components.
	typedef struct packed {
		logic signed [QuatWidth-1:0] quat_w;
		logic signed [QuatWidth-1:0] quat_x;
		logic signed [QuatWidth-1:0] quat_y;
		logic signed [QuatWidth-1:0] quat_z;
	} quat_t;

	// Lane state as it travels through the CORDIC stages.
	typedef struct packed {
		cval_t x;
		cval_t y;
		cval_t z;
		logic  flip;
	} lane_t;

	function automatic cval_t atan_q20(input int unsigned i);
		cval_t r;
		r = '0;
		case (i)
			0: r = 24'sd823550;
			1: r = 24'sd486170;
			2: r = 24'sd256879;
			3: r = 24'sd130396;
			4: r = 24'sd65451;
			5: r = 24'sd32757;
			6: r = 24'sd16383;
			7: r = 24'sd8192;
			8: r = 24'sd4096;
			9: r = 24'sd2048;
			10: r = 24'sd1024;
			11: r = 24'sd512;
			12: r = 24'sd256;
			13: r = 24'sd128;
			14: r = 24'sd64;
			15: r = 24'sd32;
			16: r = 24'sd16;
			17: r = 24'sd8;
			18: r = 24'sd4;
			19: r = 24'sd2;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

### src/eyq_if.sv
// Valid-ready channel interface carrying a generic payload.
interface eyq_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### src/eyq_cordic_stage.sv
// One CORDIC micro-rotation for one lane, combinational.
module eyq_cordic_stage
	import eyq_pkg::*;
#(
	parameter int unsigned Iter = 0
) (
	input  lane_t d,
	output lane_t q
);
	always_comb begin
		q = d;
		if (!d.z[CordicWidth-1]) begin
			q.x = d.x - (d.y >>> Iter);
			q.y = d.y + (d.x >>> Iter);
			q.z = d.z - atan_q20(Iter);
		end else begin
			q.x = d.x + (d.y >>> Iter);
			q.y = d.y - (d.x >>> Iter);
			q.z = d.z + atan_q20(Iter);
		end
	end
endmodule

### src/euler_yxz_to_quaternion_core.sv
// Top level of the Y-X-Z Euler angle to unit quaternion converter.
// Each request carries three Q3.12 angles and yields one Q1.14 quaternion. The pipeline takes a
// new request in every cycle unless stalled. Its stages are one for range reduction, ten CORDIC
// stages of two micro-rotations each, two for the pair products, one for the component products
// and one for rounding and saturation. A stall freezes the whole pipeline, and the input is ready
// whenever the output register is empty or being drained.
module euler_yxz_to_quaternion_core
	import eyq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	eyq_if.sink  angles,
	eyq_if.source quat
);
	localparam int CStages = CordicIters / 2;
	localparam int Depth   = CStages + 5;

	logic adv;
	logic [Depth-1:0] vld_q;

	assign adv          = !vld_q[Depth-1] || quat.ready;
	assign angles.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[Depth-2:0], angles.valid};
		end
	end

	// Range reduction of the half angle (raw Q3.12 read as Q2.13, widened to Q.20).
	function automatic lane_t reduce(input logic signed [AngleWidth-1:0] a);
		lane_t l;
		cval_t z;
		z = cval_t'(a) <<< 7;
		l.flip = 1'b0;
		if (z > HalfPiQ20) begin
			z = z - PiQ20;
			l.flip = 1'b1;
		end else if (z < -HalfPiQ20) begin
			z = z + PiQ20;
			l.flip = 1'b1;
		end
		l.x = CordicGainQ20;
		l.y = '0;
		l.z = z;
		return l;
	endfunction

	lane_t lane_s1 [3];
	lane_t cst_q [CStages][3];

	always_ff @(posedge clk) begin
		if (adv) begin
			lane_s1[0] <= reduce(angles.data.angle_x);
			lane_s1[1] <= reduce(angles.data.angle_y);
			lane_s1[2] <= reduce(angles.data.angle_z);
		end
	end

	for (genvar s = 0; s < CStages; s++) begin : g_stage
		for (genvar l = 0; l < 3; l++) begin : g_lane
			lane_t a, b, m;
			if (s == 0) begin : g_first
				assign a = lane_s1[l];
			end else begin : g_next
				assign a = cst_q[s-1][l];
			end
			eyq_cordic_stage #(.Iter(2*s)) u_r0 (.d(a), .q(m));
			eyq_cordic_stage #(.Iter(2*s+1)) u_r1 (.d(m), .q(b));
			always_ff @(posedge clk) begin
				if (adv) cst_q[s][l] <= b;
			end
		end
	end

	cval_t sn [3];
	cval_t cs [3];
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			sn[l] = cst_q[CStages-1][l].flip ? -cst_q[CStages-1][l].y : cst_q[CStages-1][l].y;
			cs[l] = cst_q[CStages-1][l].flip ? -cst_q[CStages-1][l].x : cst_q[CStages-1][l].x;
		end
	end

	// Pair products, raw Q.40, then rounded to Q.20 in the next stage.
	logic signed [47:0] sxsy_s2, sxcy_s2, cxcy_s2, cxsy_s2;
	cval_t sz_s2, cz_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			sxsy_s2 <= sn[0] * sn[1];
			sxcy_s2 <= sn[0] * cs[1];
			cxcy_s2 <= cs[0] * cs[1];
			cxsy_s2 <= cs[0] * sn[1];
			sz_s2   <= sn[2];
			cz_s2   <= cs[2];
		end
	end

	function automatic cval_t rnd20(input logic signed [47:0] p);
		logic signed [47:0] t;
		t = (p + 48'sd524288) >>> 20;
		return t[CordicWidth-1:0];
	endfunction

	cval_t sxsy_s3, sxcy_s3, cxcy_s3, cxsy_s3, sz_s3, cz_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			sxsy_s3 <= rnd20(sxsy_s2);
			sxcy_s3 <= rnd20(sxcy_s2);
			cxcy_s3 <= rnd20(cxcy_s2);
			cxsy_s3 <= rnd20(cxsy_s2);
			sz_s3   <= sz_s2;
			cz_s3   <= cz_s2;
		end
	end

	logic signed [47:0] pr_s4 [8];
	always_ff @(posedge clk) begin
		if (adv) begin
			pr_s4[0] <= sxsy_s3 * sz_s3;
			pr_s4[1] <= cxcy_s3 * cz_s3;
			pr_s4[2] <= sxcy_s3 * sz_s3;
			pr_s4[3] <= cxsy_s3 * cz_s3;
			pr_s4[4] <= sxcy_s3 * cz_s3;
			pr_s4[5] <= cxsy_s3 * sz_s3;
			pr_s4[6] <= cxcy_s3 * sz_s3;
			pr_s4[7] <= sxsy_s3 * cz_s3;
		end
	end

	function automatic logic signed [QuatWidth-1:0] finish(input logic signed [48:0] s);
		logic signed [48:0] v;
		logic signed [QuatWidth-1:0] r;
		v = (s + 49'sd33554432) >>> 26;
		if (v > 49'(QuatMax)) r = QuatMax;
		else if (v < -49'(QuatMax)) r = -QuatMax;
		else r = v[QuatWidth-1:0];
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			quat.data.quat_w <= finish(49'(pr_s4[0]) + 49'(pr_s4[1]));
			quat.data.quat_x <= finish(49'(pr_s4[2]) + 49'(pr_s4[3]));
			quat.data.quat_y <= finish(49'(pr_s4[4]) - 49'(pr_s4[5]));
			quat.data.quat_z <= finish(49'(pr_s4[6]) - 49'(pr_s4[7]));
		end
	end

	assign quat.valid = vld_q[Depth-1];

	// A held result must not change while the sink stalls.
	ast_hold: assert property (@(posedge clk) disable iff (!arst_n)
		quat.valid && !quat.ready |=> $stable(quat.data))
		else $error("result changed during stall");
	ast_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!quat.valid |-> angles.ready)
		else $error("input stalled with empty output");
	ast_range: assert property (@(posedge clk) disable iff (!arst_n)
		quat.valid |-> (quat.data.quat_w <= QuatMax && quat.data.quat_w >= -QuatMax))
		else $error("w out of range");
endmodule
